>>> sv/impi_pkg.sv
// Shared widths, constants and stage structs for the incremental PI speed core.
`timescale 1ns / 1ps

package impi_pkg;

    // Field widths
    localparam int SPEED_W   = 16;
    localparam int ERR_W     = SPEED_W + 1;          // signed error, +-65535
    localparam int SUM_W     = ERR_W + 1;            // e + e_prev or e - e_prev
    localparam int PMAG_W    = ERR_W + SPEED_W;      // |e + e_prev| * measured

    // Correction divisor: split into a shift and a reciprocal multiply
    localparam int SPEED_DIVISOR = 34000;
    localparam int PRE_SHIFT     = 4;
    localparam int RECIP_DIV     = SPEED_DIVISOR / (1 << PRE_SHIFT);
    localparam int QIN_W         = PMAG_W - PRE_SHIFT;
    localparam int RECIP_SHIFT   = QIN_W + $clog2(RECIP_DIV);
    localparam longint unsigned RECIP_MULT =
        ((64'd1 << RECIP_SHIFT) + 64'(RECIP_DIV) - 64'd1) / 64'(RECIP_DIV);
    localparam int RM_W          = $clog2(RECIP_MULT);
    localparam int RP_W          = QIN_W + RM_W;
    localparam int QUO_W         = RP_W - RECIP_SHIFT;

    // Drive accumulator: u_prev + (e - e_prev) + correction
    localparam int ACC_W = QUO_W + 2;

    // Stream word widths
    localparam int S_TDATA_W = 2 * SPEED_W;
    localparam int M_TDATA_W = 24;

    // Reset value of the drive limit and default output queue depth
    localparam logic [SPEED_W-1:0] DRIVE_LIMIT_RESET = 16'd1000;
    localparam int OUT_DEPTH_DEFAULT = 8;

    // Product stage to reciprocal stage
    typedef struct packed {
        logic              valid;
        logic              sel;
        logic              neg;
        logic [SUM_W-1:0]  diff;   // e - e_prev, two's complement
        logic [PMAG_W-1:0] mag;    // |e + e_prev| * measured
    } prod_t;

    // Reciprocal stage to drive stage
    typedef struct packed {
        logic             valid;
        logic             sel;
        logic             neg;
        logic [SUM_W-1:0] diff;
        logic [RP_W-1:0]  qprod;   // scaled quotient, integer part on top
    } recip_t;

    // One result word
    typedef struct packed {
        logic               sel;
        logic               reverse;
        logic [SPEED_W-1:0] duty;
    } result_t;

endpackage

>>> sv/impi_err_stage.sv
// Input register with per-channel error history, then the error-sum product stage.
`timescale 1ns / 1ps

module impi_err_stage (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid_i,
    input  logic                         in_sel_i,
    input  logic [impi_pkg::SPEED_W-1:0] in_target_i,
    input  logic [impi_pkg::SPEED_W-1:0] in_meas_i,
    output impi_pkg::prod_t              prod_o
);
    import impi_pkg::*;

    logic signed [ERR_W-1:0] perr_reg [2];
    logic signed [ERR_W-1:0] err_in;

    logic                    a_valid_reg;
    logic                    a_sel_reg;
    logic signed [ERR_W-1:0] a_err_reg;
    logic signed [ERR_W-1:0] a_perr_reg;
    logic [SPEED_W-1:0]      a_meas_reg;

    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] diff;
    logic [SUM_W-1:0]        smag;
    prod_t                   prod_next;
    prod_t                   prod_reg;

    // New error for the incoming word
    assign err_in = $signed({1'b0, in_target_i}) - $signed({1'b0, in_meas_i});

    // Capture the word and swap in its channel's error history
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            perr_reg[0] <= '0;
            perr_reg[1] <= '0;
        end else begin
            a_valid_reg <= in_valid_i;
            if (in_valid_i) begin
                perr_reg[in_sel_i] <= err_in;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid_i) begin
            a_sel_reg  <= in_sel_i;
            a_err_reg  <= err_in;
            a_perr_reg <= perr_reg[in_sel_i];
            a_meas_reg <= in_meas_i;
        end
    end

    // Error sum magnitude times measured speed; sign travels separately
    always_comb begin
        sum  = $signed({a_err_reg[ERR_W-1], a_err_reg}) +
               $signed({a_perr_reg[ERR_W-1], a_perr_reg});
        diff = $signed({a_err_reg[ERR_W-1], a_err_reg}) -
               $signed({a_perr_reg[ERR_W-1], a_perr_reg});
        smag = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);

        prod_next.valid = a_valid_reg;
        prod_next.sel   = a_sel_reg;
        prod_next.neg   = sum[SUM_W-1];
        prod_next.diff  = diff;
        prod_next.mag   = PMAG_W'(smag[ERR_W-1:0]) * PMAG_W'(a_meas_reg);
    end

    // Advance the product register; hold the payload when no word moves
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_reg.valid <= 1'b0;
        end else begin
            prod_reg.valid <= prod_next.valid;
        end
        if (prod_next.valid) begin
            prod_reg.sel  <= prod_next.sel;
            prod_reg.neg  <= prod_next.neg;
            prod_reg.diff <= prod_next.diff;
            prod_reg.mag  <= prod_next.mag;
        end
    end

    assign prod_o = prod_reg;

endmodule

>>> sv/impi_recip_stage.sv
// Divide-by-constant stage: shift out the power of two, multiply by the reciprocal.
`timescale 1ns / 1ps

module impi_recip_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  impi_pkg::prod_t  prod_i,
    output impi_pkg::recip_t recip_o
);
    import impi_pkg::*;

    logic [QIN_W-1:0] qin;
    recip_t           recip_next;
    recip_t           recip_reg;

    // Quotient = (mag >> PRE_SHIFT) * RECIP_MULT >> RECIP_SHIFT, exact for this range
    always_comb begin
        qin              = prod_i.mag[PMAG_W-1:PRE_SHIFT];
        recip_next.valid = prod_i.valid;
        recip_next.sel   = prod_i.sel;
        recip_next.neg   = prod_i.neg;
        recip_next.diff  = prod_i.diff;
        recip_next.qprod = RP_W'(qin) * RP_W'(RECIP_MULT);
    end

    // Advance the reciprocal register; hold the payload when no word moves
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            recip_reg.valid <= 1'b0;
        end else begin
            recip_reg.valid <= recip_next.valid;
        end
        if (recip_next.valid) begin
            recip_reg.sel   <= recip_next.sel;
            recip_reg.neg   <= recip_next.neg;
            recip_reg.diff  <= recip_next.diff;
            recip_reg.qprod <= recip_next.qprod;
        end
    end

    assign recip_o = recip_reg;

endmodule

>>> sv/impi_drive_stage.sv
// Drive accumulate, clamp and per-channel drive history; forms the result word.
`timescale 1ns / 1ps

module impi_drive_stage (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  impi_pkg::recip_t             recip_i,
    input  logic [impi_pkg::SPEED_W-1:0] limit_i,
    output logic                         res_valid_o,
    output impi_pkg::result_t            res_o
);
    import impi_pkg::*;

    logic signed [ERR_W-1:0] drive_reg [2];

    logic [QUO_W-1:0]        quo;
    logic signed [ACC_W-1:0] diff_x;
    logic signed [ACC_W-1:0] quo_x;
    logic signed [ACC_W-1:0] up_x;
    logic signed [ACC_W-1:0] lim_pos;
    logic signed [ACC_W-1:0] lim_neg;
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] clamped;
    logic [ACC_W-1:0]        cmag;

    // u = u_prev + (e - e_prev) +/- quotient, clamped to the limit
    always_comb begin
        quo     = recip_i.qprod[RP_W-1:RECIP_SHIFT];
        diff_x  = $signed({{(ACC_W-SUM_W){recip_i.diff[SUM_W-1]}}, recip_i.diff});
        quo_x   = $signed({{(ACC_W-QUO_W){1'b0}}, quo});
        up_x    = $signed({{(ACC_W-ERR_W){drive_reg[recip_i.sel][ERR_W-1]}},
                           drive_reg[recip_i.sel]});
        lim_pos = $signed({{(ACC_W-SPEED_W){1'b0}}, limit_i});
        lim_neg = -lim_pos;
        acc     = up_x + (recip_i.neg ? (diff_x - quo_x) : (diff_x + quo_x));

        if (acc > lim_pos) begin
            clamped = lim_pos;
        end else if (acc < lim_neg) begin
            clamped = lim_neg;
        end else begin
            clamped = acc;
        end

        cmag = clamped[ACC_W-1] ? ACC_W'(-clamped) : ACC_W'(clamped);
    end

    // Store the clamped drive as the channel's history
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drive_reg[0] <= '0;
            drive_reg[1] <= '0;
        end else if (recip_i.valid) begin
            drive_reg[recip_i.sel] <= clamped[ERR_W-1:0];
        end
    end

    assign res_valid_o   = recip_i.valid;
    assign res_o.sel     = recip_i.sel;
    assign res_o.reverse = clamped[ACC_W-1];
    assign res_o.duty    = cmag[SPEED_W-1:0];

    // Clamp must keep the duty within the limit
    a_duty_in_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        recip_i.valid |-> res_o.duty <= limit_i)
        else $error("duty above drive limit");

    // The stored drive of the updated channel stays within the limit
    a_history_in_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        recip_i.valid |=> (drive_reg[$past(recip_i.sel)] <=
                               $signed({1'b0, $past(limit_i)}))
                          && (drive_reg[$past(recip_i.sel)] >=
                               -$signed({1'b0, $past(limit_i)})))
        else $error("stored drive outside limit");

endmodule

>>> sv/impi_out_fifo.sv
// Result word queue between the pipeline and the master stream port.
`timescale 1ns / 1ps

module impi_out_fifo #(
    parameter int Depth = impi_pkg::OUT_DEPTH_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_en_i,
    input  impi_pkg::result_t wr_data_i,
    output logic              rd_valid_o,
    input  logic              rd_ready_i,
    output impi_pkg::result_t rd_data_o
);
    import impi_pkg::*;

    localparam int PTR_W = $clog2(Depth);
    localparam int CNT_W = $clog2(Depth + 1);

    result_t          mem [Depth];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             rd_en;

    assign rd_valid_o = (count_reg != '0);
    assign rd_en      = rd_valid_o && rd_ready_i;
    assign rd_data_o  = mem[rd_ptr_reg];

    // Store incoming words
    always_ff @(posedge aclk) begin
        if (wr_en_i) begin
            mem[wr_ptr_reg] <= wr_data_i;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (wr_en_i) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd_en) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            case ({wr_en_i, rd_en})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en_i |-> count_reg < CNT_W'(Depth))
        else $error("result queue overflow");

    a_empty_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == '0 |-> rd_ptr_reg == wr_ptr_reg)
        else $error("empty queue with unequal pointers");

endmodule

>>> sv/incremental_pi_motor_speed_core.sv
// Top level of the two-channel incremental PI motor speed regulator.
`timescale 1ns / 1ps

// Two-channel velocity-form PI speed regulator.
// Slave stream: one word per speed sample; tuser picks the motor (0 left,
// 1 right), tdata carries target speed [15:0] and measured speed [31:16].
// Master stream: one word per sample; tuser echoes the motor, tdata carries
// the PWM compare value [15:0] and the reverse flag [16].
// cfg_we writes cfg_wdata into the drive limit; change it only while idle.
// Each channel keeps its last error and last clamped drive; the update is
// u = u_prev + e - e_prev + ((e + e_prev) * measured) / 34000, clamped.
// Path: a word accepted on the slave side passes the input register, the
// product register and the reciprocal register, then the clamped result is
// written into the output queue, from which it shows on the master side.
// Throughput: one word per cycle while s_tready is high; the error and drive
// histories close within their stages, so back-to-back words of one motor are fine.
// s_tready drops only when OUT_DEPTH words are in flight or queued; with a
// stalled receiver the queue fills and the input side stops after OUT_DEPTH.
// Reset (aresetn low, synchronous) clears both channel histories, empties
// the pipeline and queue and sets the drive limit to 1000.
module incremental_pi_motor_speed_core #(
    parameter int OUT_DEPTH = impi_pkg::OUT_DEPTH_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Slave stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [impi_pkg::S_TDATA_W-1:0] s_tdata,   // target_speed, measured_speed
    input  logic                           s_tuser,   // motor_select
    // Master stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [impi_pkg::M_TDATA_W-1:0] m_tdata,   // duty_compare, reverse, zero fill
    output logic                           m_tuser,   // motor_echo
    // Drive limit register
    input  logic                           cfg_we,
    input  logic [impi_pkg::SPEED_W-1:0]   cfg_wdata
);
    import impi_pkg::*;

    localparam int CNT_W = $clog2(OUT_DEPTH + 1);

    logic [SPEED_W-1:0] limit_reg;
    logic [CNT_W-1:0]   inflight_reg;
    logic               s_accept;
    logic               m_accept;

    prod_t   prod;
    recip_t  recip;
    logic    res_valid;
    result_t res;
    result_t out_word;

    // Drive limit register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= DRIVE_LIMIT_RESET;
        end else if (cfg_we) begin
            limit_reg <= cfg_wdata;
        end
    end

    // Count words in the pipeline and queue; hold off input when full
    assign s_tready = (inflight_reg < CNT_W'(OUT_DEPTH));
    assign s_accept = s_tvalid && s_tready;
    assign m_accept = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            case ({s_accept, m_accept})
                2'b10:   inflight_reg <= inflight_reg + 1'b1;
                2'b01:   inflight_reg <= inflight_reg - 1'b1;
                default: inflight_reg <= inflight_reg;
            endcase
        end
    end

    impi_err_stage u_err_stage (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid_i  (s_accept),
        .in_sel_i    (s_tuser),
        .in_target_i (s_tdata[SPEED_W-1:0]),
        .in_meas_i   (s_tdata[2*SPEED_W-1:SPEED_W]),
        .prod_o      (prod)
    );

    impi_recip_stage u_recip_stage (
        .aclk    (aclk),
        .aresetn (aresetn),
        .prod_i  (prod),
        .recip_o (recip)
    );

    impi_drive_stage u_drive_stage (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .recip_i     (recip),
        .limit_i     (limit_reg),
        .res_valid_o (res_valid),
        .res_o       (res)
    );

    impi_out_fifo #(
        .Depth (OUT_DEPTH)
    ) u_out_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .wr_en_i    (res_valid),
        .wr_data_i  (res),
        .rd_valid_o (m_tvalid),
        .rd_ready_i (m_tready),
        .rd_data_o  (out_word)
    );

    // Pack the master word
    assign m_tdata = {{(M_TDATA_W-SPEED_W-1){1'b0}}, out_word.reverse, out_word.duty};
    assign m_tuser = out_word.sel;

    a_inflight_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg <= CNT_W'(OUT_DEPTH))
        else $error("in-flight count above queue depth");

    a_valid_needs_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> inflight_reg != '0)
        else $error("output valid with nothing in flight");

endmodule

>>> sim/tb.sv
// Self-checking testbench for the two-channel incremental PI motor speed core.
`timescale 1ns / 1ps

module tb;

    import impi_pkg::*;

    localparam longint SPEED_DIV  = 34000;
    localparam int     SETTLE     = 8;      // pipeline depth plus margin
    localparam int     IDLE_LIMIT = 5000;   // cycles with no word moving
    localparam int     PHASE_LEN  = 72;

    // One expected result word
    typedef struct packed {
        logic               motor;
        logic [SPEED_W-1:0] duty;
        logic               reverse;
    } drive_word_t;

    // One directed sample; known rows carry a hand-typed result
    typedef struct packed {
        logic               motor;
        logic [SPEED_W-1:0] target;
        logic [SPEED_W-1:0] meas;
        logic               known;
        logic [SPEED_W-1:0] duty;
        logic               reverse;
    } probe_row_t;

    localparam int PROBE_N = 18;
    localparam probe_row_t PROBE_TAB [PROBE_N] = '{
        // fresh channels: zero error gives zero drive
        '{1'b0, 16'd0,     16'd0,     1'b1, 16'd0,    1'b0},
        // full positive error on a fresh channel hits the reset limit
        '{1'b1, 16'd65535, 16'd0,     1'b1, 16'd1000, 1'b0},
        // full negative error hits the negative limit
        '{1'b0, 16'd0,     16'd65535, 1'b1, 16'd1000, 1'b1},
        '{1'b1, 16'd65535, 16'd65535, 1'b0, 16'd0,    1'b0},
        '{1'b0, 16'd65535, 16'd65535, 1'b0, 16'd0,    1'b0},
        '{1'b0, 16'd100,   16'd100,   1'b0, 16'd0,    1'b0},
        '{1'b1, 16'd0,     16'd0,     1'b0, 16'd0,    1'b0},
        '{1'b0, 16'd10,    16'd0,     1'b0, 16'd0,    1'b0},
        '{1'b0, 16'd0,     16'd10,    1'b0, 16'd0,    1'b0},
        '{1'b1, 16'd32768, 16'd32767, 1'b0, 16'd0,    1'b0},
        '{1'b1, 16'd1,     16'd0,     1'b0, 16'd0,    1'b0},
        '{1'b0, 16'h5555,  16'hAAAA,  1'b0, 16'd0,    1'b0},
        '{1'b1, 16'hAAAA,  16'h5555,  1'b0, 16'd0,    1'b0},
        '{1'b0, 16'd500,   16'd480,   1'b0, 16'd0,    1'b0},
        '{1'b0, 16'd500,   16'd495,   1'b0, 16'd0,    1'b0},
        '{1'b1, 16'd1000,  16'd1200,  1'b0, 16'd0,    1'b0},
        '{1'b1, 16'd1000,  16'd1000,  1'b0, 16'd0,    1'b0},
        '{1'b0, 16'd34000, 16'd34000, 1'b0, 16'd0,    1'b0}
    };

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 cfg_we    = 1'b0;
    logic [SPEED_W-1:0]   cfg_wdata = '0;

    // Predictor state: per-channel history and the current limit
    logic signed [ERR_W-1:0] last_drive [2];
    logic signed [ERR_W-1:0] last_err   [2];
    logic [SPEED_W-1:0]      drive_limit;

    drive_word_t duty_q [$];

    bit tx_gaps   = 1'b1;
    bit rx_stalls = 1'b1;
    int rx_hold   = 0;
    int idle_cnt  = 0;
    int n_errors  = 0;
    int n_samples = 0;
    int n_left    = 0;
    int n_clamped = 0;
    int n_reverse = 0;
    int n_limits  = 1;

    incremental_pi_motor_speed_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Advance one channel's regulator and return its result word
    function automatic drive_word_t regulate_speed(input logic motor,
                                                   input logic [SPEED_W-1:0] target,
                                                   input logic [SPEED_W-1:0] meas);
        drive_word_t w;
        longint err, prev_err, drive, corr, lim;
        lim      = longint'(drive_limit);
        err      = longint'(target) - longint'(meas);
        prev_err = longint'(last_err[motor]);
        corr     = ((err + prev_err) * longint'(meas)) / SPEED_DIV;
        drive    = longint'(last_drive[motor]) + err - prev_err + corr;
        if (drive > lim) begin
            drive = lim;
            n_clamped++;
        end else if (drive < -lim) begin
            drive = -lim;
            n_clamped++;
        end
        last_drive[motor] = ERR_W'(drive);
        last_err[motor]   = ERR_W'(err);
        w.motor   = motor;
        w.reverse = (drive < 0);
        w.duty    = SPEED_W'(drive < 0 ? -drive : drive);
        return w;
    endfunction

    // Drive one sample word and record what it must produce
    task automatic push_sample(input logic motor, input logic [SPEED_W-1:0] target,
                               input logic [SPEED_W-1:0] meas, input logic known,
                               input drive_word_t typed);
        int gap;
        drive_word_t want;
        gap = tx_gaps ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= motor;
        s_tdata  <= {meas, target};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        want = regulate_speed(motor, target, meas);
        if (known) want = typed;
        duty_q.push_back(want);
        n_samples++;
        if (!motor) n_left++;
        if (want.reverse) n_reverse++;
    endtask

    // Hold the sender until every expected word is back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (duty_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic load_limit(input logic [SPEED_W-1:0] value);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        drive_limit = value;
        n_limits++;
    endtask

    // Receiver: check each accepted word, then pace m_tready
    always @(posedge aclk) begin : rx_side
        drive_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (duty_q.size() == 0) begin
                $display("%0t: unexpected word motor %0d tdata %h", $time, m_tuser, m_tdata);
                n_errors++;
            end else begin
                want = duty_q.pop_front();
                if (m_tuser !== want.motor) begin
                    $display("%0t: motor expected %0d got %0d", $time, want.motor, m_tuser);
                    n_errors++;
                end
                if (m_tdata[SPEED_W-1:0] !== want.duty) begin
                    $display("%0t: duty expected %0d got %0d", $time, want.duty,
                             m_tdata[SPEED_W-1:0]);
                    n_errors++;
                end
                if (m_tdata[SPEED_W] !== want.reverse) begin
                    $display("%0t: reverse expected %0d got %0d", $time, want.reverse,
                             m_tdata[SPEED_W]);
                    n_errors++;
                end
            end
        end
        if (rx_hold > 0) begin
            rx_hold--;
            m_tready <= 1'b0;
        end else if (rx_stalls && $urandom_range(0, 2) == 0) begin
            rx_hold = pick_gap();
            m_tready <= (rx_hold == 0);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog: end the run if no word moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
            idle_cnt <= 0;
        end else if (idle_cnt >= IDLE_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d words outstanding",
                     $time, IDLE_LIMIT, duty_q.size());
            $display("tb: errors");
            $finish;
        end else begin
            idle_cnt <= idle_cnt + 1;
        end
    end

    initial begin : stimulus
        logic               motor;
        logic [SPEED_W-1:0] target, meas;
        int                 kind, t;
        logic [SPEED_W-1:0] limits [6];
        drive_word_t        typed;

        drive_limit   = DRIVE_LIMIT_RESET;
        last_drive[0] = '0;
        last_drive[1] = '0;
        last_err[0]   = '0;
        last_err[1]   = '0;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed samples at the reset limit
        foreach (PROBE_TAB[i]) begin
            typed = '{PROBE_TAB[i].motor, PROBE_TAB[i].duty, PROBE_TAB[i].reverse};
            push_sample(PROBE_TAB[i].motor, PROBE_TAB[i].target, PROBE_TAB[i].meas,
                        PROBE_TAB[i].known, typed);
        end

        // Random phases over a spread of limits, zero and full scale among them
        limits[0] = 16'd65535;
        limits[1] = 16'd0;
        limits[2] = 16'd1;
        limits[3] = SPEED_W'($urandom_range(2, 65534));
        limits[4] = 16'd1000;
        limits[5] = SPEED_W'($urandom_range(2000, 20000));
        for (int p = 0; p < 6; p++) begin
            load_limit(limits[p]);
            tx_gaps   = (p % 3 != 0);
            rx_stalls = (p % 3 != 1);
            for (int n = 0; n < PHASE_LEN; n++) begin
                motor = 1'($urandom_range(0, 1));
                kind  = $urandom_range(0, 9);
                meas  = SPEED_W'($urandom_range(0, 65535));
                if (kind < 5) begin
                    // near the set point: the error stays within +-300
                    t = int'(meas) + int'($urandom_range(0, 600)) - 300;
                    if (t < 0) t = 0;
                    if (t > 65535) t = 65535;
                    target = SPEED_W'(t);
                end else if (kind < 7) begin
                    target = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                    if ($urandom_range(0, 1)) meas = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                end else begin
                    target = SPEED_W'($urandom_range(0, 65535));
                end
                push_sample(motor, target, meas, 1'b0, '0);
                if ($urandom_range(0, 49) == 0) drain_results();
            end
        end

        drain_results();
        $display("summary: %0d samples (%0d left, %0d right) across %0d drive limits",
                 n_samples, n_left, n_samples - n_left, n_limits);
        $display("summary: %0d drives clamped, %0d in reverse, %0d mismatches",
                 n_clamped, n_reverse, n_errors);
        if (n_errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
